### rtl/dark_channel_min_filter_core_defines.svh
// Assertion macros shared by the dark channel minimum filter RTL.
// No dependencies; the including module supplies clk and arst_n.
`ifndef DARK_CHANNEL_MIN_FILTER_CORE_DEFINES_SVH
`define DARK_CHANNEL_MIN_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define DCMF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define DCMF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/dcmf_pkg.sv
// Package for the dark channel minimum filter: sizes, register reset values,
// register indexes and opcodes. No dependencies.
package dcmf_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_MAX_RADIUS = 7;

	localparam int CFG_DIM_W = 11;
	localparam int CFG_RAD_W = 3;
	localparam int PIX_W     = 8;

	localparam logic [CFG_DIM_W-1:0] RST_WIDTH  = 11'd640;
	localparam logic [CFG_DIM_W-1:0] RST_HEIGHT = 11'd480;
	localparam logic [CFG_RAD_W-1:0] RST_RADIUS = 3'd7;

	// Register indexes (byte address / 4)
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RADIUS = 2'd2;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam logic [PIX_W-1:0] PIX_MAX = '1;

endpackage

### rtl/dcmf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dcmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write, then registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/dark_channel_min_filter_core.sv
// Flow: a pixel or flush goes idle, check, then idle again if no result is ready; a pixel ignored during
// a drain stays in idle. A result adds scan (window cells, up to (2r+1)^2, one read a cycle), wait, emit.
// One item at a time: the next is taken once the check finds no result or the result sits in the output register.
// Reset (arst_n low, asynchronous): positions, drain flag and light estimate clear, registers
// return to 640 x 480, radius 7. Line store contents stay undefined until written; no clearing.
// Depends on dcmf_pkg, dcmf_ram and dark_channel_min_filter_core_defines.svh.
`include "dark_channel_min_filter_core_defines.svh"

module dark_channel_min_filter_core import dcmf_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
	input  logic        clk,
	input  logic        arst_n,
	// input pixel stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // blue [7:0], green [15:8], red [23:16]
	input  logic        s_tuser,   // opcode: 0 pixel, 1 flush
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // dark_value [7:0], atmos_light [15:8]
	output logic        m_tlast,   // last_of_frame
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int MAXD      = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int DW        = $clog2(MAXD + 1);
	localparam int RW        = $clog2(MAX_RADIUS + 1);
	localparam int LINE_ROWS = 2 * MAX_RADIUS + 2;
	localparam int SW        = $clog2(LINE_ROWS);
	localparam int DEPTH     = LINE_ROWS * MAX_WIDTH;
	localparam int AW        = $clog2(DEPTH);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_WAIT  = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0]           state_q;
	logic [CFG_DIM_W-1:0] width_q, height_q;
	logic [CFG_RAD_W-1:0] radius_q;
	logic [DW-1:0]        in_row_q, in_col_q, out_row_q, out_col_q;
	logic [SW-1:0]        in_slot_q, out_slot_q;
	logic [PIX_W-1:0]     light_q;
	logic                 draining_q;

	logic [DW-1:0]        y_q, x_q, rhi_q, clo_q, chi_q;
	logic [SW-1:0]        ys_q;
	logic [PIX_W-1:0]     acc_q;
	logic                 rd_valid_s1;

	logic                 out_valid_q, out_last_q;
	logic [PIX_W-1:0]     out_dark_q, out_light_q;

	logic [DW-1:0]        w_eff, h_eff;
	logic [RW-1:0]        r_eff;
	logic [PIX_W-1:0]     blue, green, red, cmin;
	logic                 accept, cfg_wr;
	logic                 ram_we, ram_re;
	logic [AW-1:0]        waddr, raddr;
	logic [PIX_W-1:0]     rdata;
	logic [DW:0]          row_sum, col_sum;
	logic [DW-1:0]        trow, tcol, rlo, clo, row_back;
	logic                 win_ready, scan_end, emit_go;
	logic [DW-1:0]        in_col_inc, in_row_inc, out_col_inc, out_row_inc;
	logic [SW-1:0]        in_slot_inc, out_slot_inc, ys_inc, start_slot;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);

	// Saturate register values to the supported range
	always_comb begin
		if (width_q == '0) begin
			w_eff = DW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = DW'(MAX_WIDTH);
		end else begin
			w_eff = DW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = DW'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h_eff = DW'(MAX_HEIGHT);
		end else begin
			h_eff = DW'(height_q);
		end
		if (radius_q > CFG_RAD_W'(MAX_RADIUS)) begin
			r_eff = RW'(MAX_RADIUS);
		end else begin
			r_eff = RW'(radius_q);
		end
	end

	// Register read-back
	always_comb begin
		prdata = '0;
		case (paddr[3:2])
			REG_WIDTH:  prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
			REG_RADIUS: prdata = 32'(radius_q);
			default:    prdata = '0;
		endcase
	end

	// Channel minimum of the incoming pixel
	assign blue  = s_tdata[7:0];
	assign green = s_tdata[15:8];
	assign red   = s_tdata[23:16];
	always_comb begin
		cmin = blue;
		if (green < cmin) begin
			cmin = green;
		end
		if (red < cmin) begin
			cmin = red;
		end
	end

	assign ram_we = accept && (s_tuser == OP_PIXEL) && !draining_q;
	assign waddr  = AW'(in_slot_q) * AW'(MAX_WIDTH) + AW'(in_col_q);
	assign ram_re = (state_q == ST_SCAN);
	assign raddr  = AW'(ys_q) * AW'(MAX_WIDTH) + AW'(x_q);

	dcmf_ram #(
		.WIDTH(PIX_W),
		.DEPTH(DEPTH)
	) u_line_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(cmin),
		.re   (ram_re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Window bounds and readiness of the next result
	always_comb begin
		row_sum = {1'b0, out_row_q} + (DW+1)'(r_eff);
		col_sum = {1'b0, out_col_q} + (DW+1)'(r_eff);
		trow = (row_sum < {1'b0, h_eff - DW'(1)}) ? row_sum[DW-1:0] : h_eff - DW'(1);
		tcol = (col_sum < {1'b0, w_eff - DW'(1)}) ? col_sum[DW-1:0] : w_eff - DW'(1);
		rlo  = (out_row_q > DW'(r_eff)) ? out_row_q - DW'(r_eff) : '0;
		clo  = (out_col_q > DW'(r_eff)) ? out_col_q - DW'(r_eff) : '0;
		row_back = out_row_q - rlo;
		if (DW'(out_slot_q) >= row_back) begin
			start_slot = out_slot_q - SW'(row_back);
		end else begin
			start_slot = SW'(DW'(out_slot_q) + DW'(LINE_ROWS) - row_back);
		end
		win_ready = draining_q || (in_row_q > trow) || ((in_row_q == trow) && (in_col_q > tcol));
	end

	// Position increments with slot wrap
	always_comb begin
		in_col_inc   = in_col_q + DW'(1);
		in_row_inc   = in_row_q + DW'(1);
		out_col_inc  = out_col_q + DW'(1);
		out_row_inc  = out_row_q + DW'(1);
		in_slot_inc  = (in_slot_q == SW'(LINE_ROWS - 1)) ? '0 : in_slot_q + SW'(1);
		out_slot_inc = (out_slot_q == SW'(LINE_ROWS - 1)) ? '0 : out_slot_q + SW'(1);
		ys_inc       = (ys_q == SW'(LINE_ROWS - 1)) ? '0 : ys_q + SW'(1);
		scan_end     = (x_q == chi_q) && (y_q == rhi_q);
		emit_go      = (state_q == ST_EMIT) && (!out_valid_q || m_tready);
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			radius_q <= RST_RADIUS;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_WIDTH:  width_q  <= pwdata[CFG_DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[CFG_DIM_W-1:0];
				REG_RADIUS: radius_q <= pwdata[CFG_RAD_W-1:0];
				default:    ;
			endcase
		end
	end

	// Sequencer: accept, check, scan window, wait, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_row_q    <= '0;
			in_col_q    <= '0;
			in_slot_q   <= '0;
			out_row_q   <= '0;
			out_col_q   <= '0;
			out_slot_q  <= '0;
			light_q     <= '0;
			draining_q  <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= ram_re;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser == OP_FLUSH) begin
							state_q <= ST_CHECK;
						end else if (!draining_q) begin
							state_q <= ST_CHECK;
							if (cmin > light_q) begin
								light_q <= cmin;
							end
							if (in_col_inc >= w_eff) begin
								in_col_q <= '0;
								if (in_row_inc >= h_eff) begin
									in_row_q   <= '0;
									in_slot_q  <= '0;
									draining_q <= 1'b1;
								end else begin
									in_row_q  <= in_row_inc;
									in_slot_q <= in_slot_inc;
								end
							end else begin
								in_col_q <= in_col_inc;
							end
						end
					end
				end
				ST_CHECK: begin
					state_q <= win_ready ? ST_SCAN : ST_IDLE;
				end
				ST_SCAN: begin
					if (scan_end) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
						if (out_col_inc >= w_eff) begin
							out_col_q <= '0;
							if (out_row_inc >= h_eff) begin
								out_row_q  <= '0;
								out_slot_q <= '0;
								draining_q <= 1'b0;
							end else begin
								out_row_q  <= out_row_inc;
								out_slot_q <= out_slot_inc;
							end
						end else begin
							out_col_q <= out_col_inc;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Window walk and running minimum
	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) begin
			y_q   <= rlo;
			ys_q  <= start_slot;
			x_q   <= clo;
			clo_q <= clo;
			chi_q <= tcol;
			rhi_q <= trow;
			acc_q <= PIX_MAX;
		end else begin
			if (state_q == ST_SCAN && !scan_end) begin
				if (x_q == chi_q) begin
					x_q  <= clo_q;
					y_q  <= y_q + DW'(1);
					ys_q <= ys_inc;
				end else begin
					x_q <= x_q + DW'(1);
				end
			end
			if (rd_valid_s1 && rdata < acc_q) begin
				acc_q <= rdata;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_dark_q  <= acc_q;
			out_light_q <= light_q;
			out_last_q  <= (out_col_inc >= w_eff) && (out_row_inc >= h_eff);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_light_q, out_dark_q};
	assign m_tlast  = out_last_q;

	`DCMF_ASSERT_NOW(a_no_write_in_scan, ram_we, state_q == ST_IDLE,
		"line store written outside idle")
	`DCMF_ASSERT_NOW(a_scan_in_bounds, state_q == ST_SCAN,
		(x_q <= chi_q) && (y_q <= rhi_q) && (32'(ys_q) < LINE_ROWS),
		"window walk out of bounds")
	`DCMF_ASSERT_NEXT(a_read_then_wait, (state_q == ST_SCAN) && scan_end,
		(state_q == ST_WAIT) && rd_valid_s1, "last window read not followed by wait")
	`DCMF_ASSERT_NEXT(a_emit_loads_output, emit_go, m_tvalid && (state_q == ST_IDLE),
		"emitted result not presented")

endmodule
